FILE: sv/cmi_pkg.sv
// Shared constants and types for the clock mapping interpolator.
// Used by every module of the block; depends on nothing.
package cmi_pkg;

    localparam int DEV_W  = 32;
    localparam int HOST_W = 63;
    localparam int SRC_W  = 3;
    localparam int PROD_W = 2 * DEV_W;
    localparam int ACC_W  = 3 * DEV_W;
    localparam int QUO_W  = 2 * DEV_W;
    localparam int DIV_CNT_W = $clog2(QUO_W + 1);

    localparam logic REQ_RECORD = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    localparam logic [SRC_W-1:0] SRC_FALLBACK = 3'd0;
    localparam logic [SRC_W-1:0] SRC_SINGLE   = 3'd1;
    localparam logic [SRC_W-1:0] SRC_INTERP   = 3'd2;
    localparam logic [SRC_W-1:0] SRC_EQUAL    = 3'd3;
    localparam logic [SRC_W-1:0] SRC_NEWEST   = 3'd4;

    localparam logic [DEV_W-1:0]  MS_TO_NS = 32'd1000000;
    localparam logic [HOST_W-1:0] HOST_MAX = {HOST_W{1'b1}};

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

FILE: sv/cmi_pair_mem.sv
// Pair storage: device ms and host ns per slot, one write and one read port.
// Depends on cmi_pkg for field widths.
module cmi_pair_mem #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [ADDR_W-1:0]           wr_addr,
    input  logic [cmi_pkg::DEV_W-1:0]   wr_dev,
    input  logic [cmi_pkg::HOST_W-1:0]  wr_host,
    input  logic [ADDR_W-1:0]           rd_addr,
    output logic [cmi_pkg::DEV_W-1:0]   rd_dev,
    output logic [cmi_pkg::HOST_W-1:0]  rd_host
);

    logic [cmi_pkg::DEV_W-1:0]  dev_mem  [DEPTH];
    logic [cmi_pkg::HOST_W-1:0] host_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            dev_mem[wr_addr]  <= wr_dev;
            host_mem[wr_addr] <= wr_host;
        end
        rd_dev  <= dev_mem[rd_addr];
        rd_host <= host_mem[rd_addr];
    end

endmodule

FILE: sv/cmi_div.sv
// Serial restoring divider: 96-bit dividend by 32-bit divisor, one quotient bit a cycle.
// Requires dividend[95:64] < divisor. Depends on cmi_pkg.
module cmi_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [cmi_pkg::ACC_W-1:0]    dividend,
    input  logic [cmi_pkg::DEV_W-1:0]    divisor,
    output logic [cmi_pkg::QUO_W-1:0]    quotient,
    output cmi_pkg::div_stat_t           stat
);

    logic [cmi_pkg::DEV_W-1:0]     rem_reg, rem_next;
    logic [cmi_pkg::QUO_W-1:0]     quo_reg, quo_next;
    logic [cmi_pkg::DEV_W-1:0]     dsr_reg, dsr_next;
    logic [cmi_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          done_reg, done_next;
    logic [cmi_pkg::DEV_W:0]       trial;
    logic                          take;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[cmi_pkg::QUO_W-1]};
        take      = trial >= {1'b0, dsr_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = dividend[cmi_pkg::ACC_W-1:cmi_pkg::QUO_W];
            quo_next = dividend[cmi_pkg::QUO_W-1:0];
            dsr_next = divisor;
            cnt_next = cmi_pkg::DIV_CNT_W'(cmi_pkg::QUO_W);
        end
        else if (cnt_reg != '0)
        begin
            if (take)
            begin
                rem_next = cmi_pkg::DEV_W'(trial - {1'b0, dsr_reg});
            end
            else
            begin
                rem_next = trial[cmi_pkg::DEV_W-1:0];
            end
            quo_next  = {quo_reg[cmi_pkg::QUO_W-2:0], take};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == cmi_pkg::DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;

endmodule

FILE: sv/clock_mapping_interpolator_top.sv
// Clock mapping interpolator top level: sequencer, shared multiplier and result register.
// Depends on cmi_pkg, cmi_pair_mem and cmi_div.
//
// Input channel (in_valid / in_stall) carries one request per transaction.
// req_type record appends a (device_ms, host_ns) pair to a FIFO of PAIR_DEPTH
// pairs, dropping the oldest when full, and yields no result. req_type query
// maps device_ms to host time and yields one result transaction on the output
// channel (out_valid / out_stall): mapped_ns, map_source, saturated.
// A record is written to the pair memory when it is accepted. A query passes through the
// accepting cycle and the output load, plus one memory read and one compare per stored
// pair scanned, plus a multiply and an offset step for a single pair, or, for
// interpolation, two multiplier steps, one accumulate, one divider start and a wait on
// the 64-step serial divider. A finished result also waits while out_stall holds the
// output register. in_stall is high from the cycle after a query is accepted until its
// result is loaded.
// The output register holds a result until the receiver takes it; a record is
// still accepted meanwhile, while a finished query waits while out_stall holds.
// Reset empties the FIFO and clears out_valid; the pair memory is not cleared,
// since only slots written by a record are ever read.
module clock_mapping_interpolator_top #(
    parameter int PAIR_DEPTH = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        req_type,
    input  logic [cmi_pkg::DEV_W-1:0]   device_ms,
    input  logic [cmi_pkg::HOST_W-1:0]  host_ns,
    input  logic [cmi_pkg::HOST_W-1:0]  fallback_ns,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [cmi_pkg::HOST_W-1:0]  mapped_ns,
    output logic [cmi_pkg::SRC_W-1:0]   map_source,
    output logic                        saturated
);

    localparam int SLOT_W = $clog2(PAIR_DEPTH);
    localparam int CNT_W  = $clog2(PAIR_DEPTH + 1);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_RD       = 4'd1;
    localparam logic [3:0] S_EVAL     = 4'd2;
    localparam logic [3:0] S_MUL_SP   = 4'd3;
    localparam logic [3:0] S_SP       = 4'd4;
    localparam logic [3:0] S_MUL_LO   = 4'd5;
    localparam logic [3:0] S_MUL_HI   = 4'd6;
    localparam logic [3:0] S_ACC      = 4'd7;
    localparam logic [3:0] S_DIV_GO   = 4'd8;
    localparam logic [3:0] S_DIV_WAIT = 4'd9;
    localparam logic [3:0] S_FINISH   = 4'd10;

    logic [3:0]                  state_reg, state_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [SLOT_W-1:0]           oldest_reg, oldest_next;
    logic [SLOT_W-1:0]           k_reg, k_next;
    logic                        out_valid_reg, out_valid_next;

    logic [cmi_pkg::DEV_W-1:0]   q_dev_reg, q_dev_next;
    logic [cmi_pkg::DEV_W-1:0]   prev_dev_reg, prev_dev_next;
    logic [cmi_pkg::HOST_W-1:0]  prev_host_reg, prev_host_next;
    logic [cmi_pkg::DEV_W-1:0]   num_reg, num_next;
    logic [cmi_pkg::DEV_W-1:0]   dt_reg, dt_next;
    logic [cmi_pkg::HOST_W-1:0]  mag_reg, mag_next;
    logic                        neg_reg, neg_next;
    logic [cmi_pkg::ACC_W-1:0]   acc_reg, acc_next;
    logic [cmi_pkg::PROD_W-1:0]  mul_reg, mul_next;
    logic [cmi_pkg::HOST_W-1:0]  fin_res_reg, fin_res_next;
    logic [cmi_pkg::SRC_W-1:0]   fin_src_reg, fin_src_next;
    logic                        fin_sat_reg, fin_sat_next;
    logic [cmi_pkg::HOST_W-1:0]  mapped_ns_reg, mapped_ns_next;
    logic [cmi_pkg::SRC_W-1:0]   map_source_reg, map_source_next;
    logic                        saturated_reg, saturated_next;

    logic                        in_accept;
    logic                        wr_en;
    logic [SLOT_W-1:0]           wr_slot;
    logic [SLOT_W-1:0]           rd_slot;
    logic [cmi_pkg::DEV_W-1:0]   rd_dev;
    logic [cmi_pkg::HOST_W-1:0]  rd_host;
    logic [cmi_pkg::DEV_W-1:0]   mul_a;
    logic [cmi_pkg::DEV_W-1:0]   mul_b;
    logic                        div_start;
    logic [cmi_pkg::QUO_W-1:0]   quotient;
    cmi_pkg::div_stat_t          div_stat;
    logic [cmi_pkg::PROD_W-1:0]  sum64;
    logic                        bracket;
    logic                        last_pair;

    function automatic logic [SLOT_W-1:0] wrap_slot(input logic [SLOT_W-1:0] base,
                                                    input logic [SLOT_W-1:0] offs);
        logic [SLOT_W:0] s;
        begin
            s = {1'b0, base} + {1'b0, offs};
            if (s >= (SLOT_W+1)'(PAIR_DEPTH))
            begin
                s = s - (SLOT_W+1)'(PAIR_DEPTH);
            end
            return s[SLOT_W-1:0];
        end
    endfunction

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign rd_slot   = wrap_slot(oldest_reg, k_reg);
    assign wr_en     = in_accept && (req_type == cmi_pkg::REQ_RECORD);
    assign wr_slot   = (count_reg < CNT_W'(PAIR_DEPTH))
                     ? wrap_slot(oldest_reg, count_reg[SLOT_W-1:0]) : oldest_reg;
    assign bracket   = (q_dev_reg >= prev_dev_reg) && (q_dev_reg <= rd_dev);
    assign last_pair = ((CNT_W'(k_reg) + 1'b1) == count_reg);
    assign sum64     = {1'b0, prev_host_reg} + mul_reg;
    assign div_start = (state_reg == S_DIV_GO);

    cmi_pair_mem #(
        .DEPTH  (PAIR_DEPTH),
        .ADDR_W (SLOT_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_slot),
        .wr_dev  (device_ms),
        .wr_host (host_ns),
        .rd_addr (rd_slot),
        .rd_dev  (rd_dev),
        .rd_host (rd_host)
    );

    cmi_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_reg),
        .divisor  (dt_reg),
        .quotient (quotient),
        .stat     (div_stat)
    );

    always_comb
    begin
        case (state_reg)
            S_MUL_SP:
            begin
                mul_a = num_reg;
                mul_b = cmi_pkg::MS_TO_NS;
            end
            S_MUL_HI:
            begin
                mul_a = {1'b0, mag_reg[cmi_pkg::HOST_W-1:cmi_pkg::DEV_W]};
                mul_b = num_reg;
            end
            default:
            begin
                mul_a = mag_reg[cmi_pkg::DEV_W-1:0];
                mul_b = num_reg;
            end
        endcase
        mul_next = cmi_pkg::PROD_W'(mul_a) * cmi_pkg::PROD_W'(mul_b);
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        oldest_next     = oldest_reg;
        k_next          = k_reg;
        out_valid_next  = out_valid_reg && out_stall;
        q_dev_next      = q_dev_reg;
        prev_dev_next   = prev_dev_reg;
        prev_host_next  = prev_host_reg;
        num_next        = num_reg;
        dt_next         = dt_reg;
        mag_next        = mag_reg;
        neg_next        = neg_reg;
        acc_next        = acc_reg;
        fin_res_next    = fin_res_reg;
        fin_src_next    = fin_src_reg;
        fin_sat_next    = fin_sat_reg;
        mapped_ns_next  = mapped_ns_reg;
        map_source_next = map_source_reg;
        saturated_next  = saturated_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (req_type == cmi_pkg::REQ_RECORD)
                    begin
                        if (count_reg < CNT_W'(PAIR_DEPTH))
                        begin
                            count_next = count_reg + 1'b1;
                        end
                        else
                        begin
                            oldest_next = wrap_slot(oldest_reg, SLOT_W'(1));
                        end
                    end
                    else
                    begin
                        q_dev_next   = device_ms;
                        k_next       = '0;
                        fin_sat_next = 1'b0;
                        if (count_reg == '0)
                        begin
                            fin_res_next = fallback_ns;
                            fin_src_next = cmi_pkg::SRC_FALLBACK;
                            state_next   = S_FINISH;
                        end
                        else
                        begin
                            state_next = S_RD;
                        end
                    end
                end
            end
            S_RD:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                prev_dev_next  = rd_dev;
                prev_host_next = rd_host;
                if (k_reg == '0)
                begin
                    if (count_reg == CNT_W'(1))
                    begin
                        neg_next   = q_dev_reg < rd_dev;
                        num_next   = (q_dev_reg < rd_dev) ? rd_dev - q_dev_reg
                                                          : q_dev_reg - rd_dev;
                        state_next = S_MUL_SP;
                    end
                    else
                    begin
                        k_next     = SLOT_W'(1);
                        state_next = S_RD;
                    end
                end
                else if (bracket)
                begin
                    prev_dev_next  = prev_dev_reg;
                    prev_host_next = prev_host_reg;
                    if (rd_dev == prev_dev_reg)
                    begin
                        fin_res_next = rd_host;
                        fin_src_next = cmi_pkg::SRC_EQUAL;
                        state_next   = S_FINISH;
                    end
                    else
                    begin
                        num_next   = q_dev_reg - prev_dev_reg;
                        dt_next    = rd_dev - prev_dev_reg;
                        neg_next   = rd_host < prev_host_reg;
                        mag_next   = (rd_host < prev_host_reg) ? prev_host_reg - rd_host
                                                               : rd_host - prev_host_reg;
                        state_next = S_MUL_LO;
                    end
                end
                else if (last_pair)
                begin
                    fin_res_next = rd_host;
                    fin_src_next = cmi_pkg::SRC_NEWEST;
                    state_next   = S_FINISH;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_RD;
                end
            end
            S_MUL_SP:
            begin
                state_next = S_SP;
            end
            S_SP:
            begin
                fin_src_next = cmi_pkg::SRC_SINGLE;
                if (!neg_reg)
                begin
                    fin_sat_next = sum64[cmi_pkg::PROD_W-1];
                    fin_res_next = sum64[cmi_pkg::PROD_W-1] ? cmi_pkg::HOST_MAX
                                                           : sum64[cmi_pkg::HOST_W-1:0];
                end
                else if (mul_reg > {1'b0, prev_host_reg})
                begin
                    fin_sat_next = 1'b1;
                    fin_res_next = '0;
                end
                else
                begin
                    fin_res_next = prev_host_reg - mul_reg[cmi_pkg::HOST_W-1:0];
                end
                state_next = S_FINISH;
            end
            S_MUL_LO:
            begin
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                acc_next   = cmi_pkg::ACC_W'(mul_reg);
                state_next = S_ACC;
            end
            S_ACC:
            begin
                acc_next   = acc_reg + {mul_reg, {cmi_pkg::DEV_W{1'b0}}};
                state_next = S_DIV_GO;
            end
            S_DIV_GO:
            begin
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_stat.done)
                begin
                    fin_src_next = cmi_pkg::SRC_INTERP;
                    fin_res_next = neg_reg ? prev_host_reg - quotient[cmi_pkg::HOST_W-1:0]
                                           : prev_host_reg + quotient[cmi_pkg::HOST_W-1:0];
                    state_next   = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    mapped_ns_next  = fin_res_reg;
                    map_source_next = fin_src_reg;
                    saturated_next  = fin_sat_reg;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            oldest_reg    <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            oldest_reg    <= oldest_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_dev_reg      <= q_dev_next;
        prev_dev_reg   <= prev_dev_next;
        prev_host_reg  <= prev_host_next;
        num_reg        <= num_next;
        dt_reg         <= dt_next;
        mag_reg        <= mag_next;
        neg_reg        <= neg_next;
        acc_reg        <= acc_next;
        mul_reg        <= mul_next;
        fin_res_reg    <= fin_res_next;
        fin_src_reg    <= fin_src_next;
        fin_sat_reg    <= fin_sat_next;
        mapped_ns_reg  <= mapped_ns_next;
        map_source_reg <= map_source_next;
        saturated_reg  <= saturated_next;
    end

    assign out_valid  = out_valid_reg;
    assign mapped_ns  = mapped_ns_reg;
    assign map_source = map_source_reg;
    assign saturated  = saturated_reg;

endmodule

FILE: verif/clock_mapping_interpolator_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for clock_mapping_interpolator_top: directed table, then random
// record/query streams under varying idle and stall pressure, checked by an in-line predictor.
// Depends on cmi_pkg and clock_mapping_interpolator_top.
module clock_mapping_interpolator_top_tb;

    localparam int PAIR_DEPTH  = 16;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int PHASE_ITEMS = 445;

    typedef struct packed {
        logic [cmi_pkg::HOST_W-1:0] mapped_ns;
        logic [cmi_pkg::SRC_W-1:0]  source;
        logic                       saturated;
    } map_result_t;

    typedef struct {
        logic                       req;
        logic [cmi_pkg::DEV_W-1:0]  dms;
        logic [cmi_pkg::HOST_W-1:0] hns;
        logic [cmi_pkg::HOST_W-1:0] fb;
        bit                         typed;
        map_result_t                want;
    } stim_row_t;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic                       req_type;
    logic [cmi_pkg::DEV_W-1:0]  device_ms;
    logic [cmi_pkg::HOST_W-1:0] host_ns;
    logic [cmi_pkg::HOST_W-1:0] fallback_ns;
    logic                       out_valid;
    logic                       out_stall;
    logic [cmi_pkg::HOST_W-1:0] mapped_ns;
    logic [cmi_pkg::SRC_W-1:0]  map_source;
    logic                       saturated;

    bit                         row_typed;
    map_result_t                row_expect;

    logic [cmi_pkg::DEV_W-1:0]  pair_key [PAIR_DEPTH];
    logic [cmi_pkg::HOST_W-1:0] pair_host [PAIR_DEPTH];
    int                         pair_total;
    int                         pair_head;

    map_result_t                expected_maps [$];
    stim_row_t                  directed_rows [$];
    int                         error_count;
    int                         cycle_count;
    int                         send_idle_pct;
    int                         stall_pct;
    bit                         hold_go;
    logic [cmi_pkg::DEV_W-1:0]  tl_dev;
    logic [cmi_pkg::HOST_W-1:0] tl_host;

    clock_mapping_interpolator_top #(
        .PAIR_DEPTH(PAIR_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .req_type(req_type),
        .device_ms(device_ms),
        .host_ns(host_ns),
        .fallback_ns(fallback_ns),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .mapped_ns(mapped_ns),
        .map_source(map_source),
        .saturated(saturated)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int slot_at(input int k);
        return (pair_head + k) % PAIR_DEPTH;
    endfunction

    function automatic void add_expected(input map_result_t r);
        expected_maps.insert(expected_maps.size(), r);
    endfunction

    function automatic map_result_t next_expected();
        map_result_t r;
        r = expected_maps[0];
        expected_maps.delete(0);
        return r;
    endfunction

    function automatic void store_pair(input logic [cmi_pkg::DEV_W-1:0] dms,
                                       input logic [cmi_pkg::HOST_W-1:0] hns);
        int s;
        if (pair_total < PAIR_DEPTH)
        begin
            s = slot_at(pair_total);
            pair_total++;
        end
        else
        begin
            s = pair_head;
            pair_head = (pair_head + 1) % PAIR_DEPTH;
        end
        pair_key[s]  = dms;
        pair_host[s] = hns;
    endfunction

    function automatic logic [cmi_pkg::HOST_W-1:0] scale_span(
            input logic [cmi_pkg::HOST_W-1:0] mag,
            input logic [cmi_pkg::DEV_W-1:0]  num,
            input logic [cmi_pkg::DEV_W-1:0]  den);
        logic [127:0] prod;
        logic [127:0] quo;
        prod = {65'd0, mag} * {96'd0, num};
        quo  = prod / {96'd0, den};
        return quo[cmi_pkg::HOST_W-1:0];
    endfunction

    function automatic map_result_t map_query(input logic [cmi_pkg::DEV_W-1:0] q,
                                              input logic [cmi_pkg::HOST_W-1:0] fb);
        map_result_t                r;
        logic [64:0]                wide;
        logic [64:0]                h65;
        logic [cmi_pkg::DEV_W-1:0]  span;
        logic [cmi_pkg::DEV_W-1:0]  da;
        logic [cmi_pkg::DEV_W-1:0]  db;
        logic [cmi_pkg::HOST_W-1:0] ha;
        logic [cmi_pkg::HOST_W-1:0] hb;
        bit                         found;
        r = '0;
        if (pair_total == 0)
        begin
            r.mapped_ns = fb;
            r.source    = cmi_pkg::SRC_FALLBACK;
        end
        else if (pair_total == 1)
        begin
            h65 = {2'b00, pair_host[pair_head]};
            da  = pair_key[pair_head];
            r.source = cmi_pkg::SRC_SINGLE;
            if (q >= da)
            begin
                span = q - da;
                wide = h65 + {33'd0, span} * {33'd0, cmi_pkg::MS_TO_NS};
                if (wide > {2'b00, cmi_pkg::HOST_MAX})
                begin
                    r.mapped_ns = cmi_pkg::HOST_MAX;
                    r.saturated = 1'b1;
                end
                else
                    r.mapped_ns = wide[cmi_pkg::HOST_W-1:0];
            end
            else
            begin
                span = da - q;
                wide = {33'd0, span} * {33'd0, cmi_pkg::MS_TO_NS};
                if (wide > h65)
                begin
                    r.mapped_ns = '0;
                    r.saturated = 1'b1;
                end
                else
                    r.mapped_ns = pair_host[pair_head] - wide[cmi_pkg::HOST_W-1:0];
            end
        end
        else
        begin
            found = 1'b0;
            for (int k = 1; k < pair_total && !found; k++)
            begin
                da = pair_key[slot_at(k - 1)];
                db = pair_key[slot_at(k)];
                if (q >= da && q <= db)
                begin
                    found = 1'b1;
                    ha = pair_host[slot_at(k - 1)];
                    hb = pair_host[slot_at(k)];
                    if (db == da)
                    begin
                        r.mapped_ns = hb;
                        r.source    = cmi_pkg::SRC_EQUAL;
                    end
                    else
                    begin
                        r.source = cmi_pkg::SRC_INTERP;
                        if (hb >= ha)
                            r.mapped_ns = ha + scale_span(hb - ha, q - da, db - da);
                        else
                            r.mapped_ns = ha - scale_span(ha - hb, q - da, db - da);
                    end
                end
            end
            if (!found)
            begin
                r.mapped_ns = pair_host[slot_at(pair_total - 1)];
                r.source    = cmi_pkg::SRC_NEWEST;
            end
        end
        return r;
    endfunction

    always @(posedge clk)
    begin : result_check
        map_result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_maps.size() == 0)
                begin
                    $display("%0t: unexpected result: mapped_ns %0d source %0d saturated %0b",
                             $time, mapped_ns, map_source, saturated);
                    error_count++;
                end
                else
                begin
                    want = next_expected();
                    if (mapped_ns !== want.mapped_ns)
                    begin
                        $display("%0t: mapped_ns expected %0d actual %0d",
                                 $time, want.mapped_ns, mapped_ns);
                        error_count++;
                    end
                    if (map_source !== want.source)
                    begin
                        $display("%0t: map_source expected %0d actual %0d",
                                 $time, want.source, map_source);
                        error_count++;
                    end
                    if (saturated !== want.saturated)
                    begin
                        $display("%0t: saturated expected %0b actual %0b",
                                 $time, want.saturated, saturated);
                        error_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                if (req_type == cmi_pkg::REQ_RECORD)
                    store_pair(device_ms, host_ns);
                else if (row_typed)
                    add_expected(row_expect);
                else
                    add_expected(map_query(device_ms, fallback_ns));
            end
        end
    end

    initial
    begin : receiver
        int hold_left;
        bit hold_started;
        hold_left    = 0;
        hold_started = 1'b0;
        out_stall    = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_go && !hold_started)
            begin
                hold_started = 1'b1;
                hold_left    = 400;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    task automatic offer(input logic req, input logic [cmi_pkg::DEV_W-1:0] dms,
                         input logic [cmi_pkg::HOST_W-1:0] hns,
                         input logic [cmi_pkg::HOST_W-1:0] fb,
                         input bit typed, input map_result_t want);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= req;
        device_ms   <= dms;
        host_ns     <= hns;
        fallback_ns <= fb;
        row_typed   <= typed;
        row_expect  <= want;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain_results();
        while (expected_maps.size() != 0)
            @(posedge clk);
    endtask

    task automatic row(input logic req, input logic [cmi_pkg::DEV_W-1:0] dms,
                       input logic [cmi_pkg::HOST_W-1:0] hns,
                       input logic [cmi_pkg::HOST_W-1:0] fb,
                       input bit typed, input logic [cmi_pkg::HOST_W-1:0] ns,
                       input logic [cmi_pkg::SRC_W-1:0] src, input logic sat);
        stim_row_t r;
        r.req  = req;
        r.dms  = dms;
        r.hns  = hns;
        r.fb   = fb;
        r.typed = typed;
        r.want.mapped_ns = ns;
        r.want.source    = src;
        r.want.saturated = sat;
        directed_rows.insert(directed_rows.size(), r);
    endtask

    function automatic logic [cmi_pkg::HOST_W-1:0] rand_host();
        logic [63:0] raw;
        int          pick;
        raw  = {$urandom, $urandom};
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return cmi_pkg::HOST_MAX;
        if (pick == 1)
            return '0;
        if (pick == 2)
            return {31'd0, raw[31:0]};
        return raw[cmi_pkg::HOST_W-1:0];
    endfunction

    function automatic logic [cmi_pkg::DEV_W-1:0] pick_query_key();
        int                        k;
        logic [cmi_pkg::DEV_W-1:0] lo;
        logic [cmi_pkg::DEV_W-1:0] hi;
        int                        pick;
        if (pair_total < 2)
            return $urandom;
        k  = $urandom_range(1, pair_total - 1);
        lo = pair_key[slot_at(k - 1)];
        hi = pair_key[slot_at(k)];
        if (lo > hi)
        begin
            lo = pair_key[slot_at(k)];
            hi = pair_key[slot_at(k - 1)];
        end
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return lo;
        if (pick == 1)
            return hi;
        if (pick == 2)
            return hi + $urandom_range(1, 1000);
        if (pick == 3)
            return lo - $urandom_range(1, 1000);
        return lo + $urandom_range(0, hi - lo);
    endfunction

    task automatic random_item();
        int                         pick;
        int                         step;
        logic [cmi_pkg::DEV_W-1:0]  dms;
        logic [cmi_pkg::HOST_W-1:0] hns;
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            if ($urandom_range(0, 49) == 0)
            begin
                tl_dev  = ($urandom_range(0, 3) == 0) ? 32'hFFFF_F000 : $urandom;
                tl_host = rand_host();
            end
            else
            begin
                step = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 100000)
                                                   : $urandom_range(0, 1000);
                tl_dev  = tl_dev + step;
                tl_host = tl_host + 63'(step) * 63'd1000000
                          + 63'($urandom_range(0, 2000000)) - 63'd1000000;
            end
            offer(cmi_pkg::REQ_RECORD, tl_dev, tl_host, rand_host(), 1'b0, '0);
        end
        else if (pick < 85)
            offer(cmi_pkg::REQ_QUERY, pick_query_key(), rand_host(), rand_host(), 1'b0, '0);
        else if (pick < 92)
        begin
            dms = ($urandom_range(0, 2) == 0) ? tl_dev : $urandom;
            hns = rand_host();
            offer(cmi_pkg::REQ_RECORD, dms, hns, rand_host(), 1'b0, '0);
        end
        else
        begin
            dms = ($urandom_range(0, 1) == 0) ? $urandom : pair_key[slot_at(0)];
            offer(cmi_pkg::REQ_QUERY, dms, rand_host(), rand_host(), 1'b0, '0);
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        req_type      = cmi_pkg::REQ_RECORD;
        device_ms     = '0;
        host_ns       = '0;
        fallback_ns   = '0;
        row_typed     = 1'b0;
        row_expect    = '0;
        pair_total    = 0;
        pair_head     = 0;
        error_count   = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_go       = 1'b0;
        tl_dev        = $urandom_range(0, 1000000);
        tl_host       = rand_host();

        // Empty FIFO, then a single pair near the top of the host range.
        row(cmi_pkg::REQ_QUERY, 32'd0, '0, '0, 1'b1, '0, cmi_pkg::SRC_FALLBACK, 1'b0);
        row(cmi_pkg::REQ_QUERY, 32'hFFFF_FFFF, cmi_pkg::HOST_MAX, cmi_pkg::HOST_MAX, 1'b1,
            cmi_pkg::HOST_MAX, cmi_pkg::SRC_FALLBACK, 1'b0);
        row(cmi_pkg::REQ_QUERY, 32'd123, '0, 63'd5555, 1'b1, 63'd5555,
            cmi_pkg::SRC_FALLBACK, 1'b0);
        row(cmi_pkg::REQ_RECORD, 32'd2000, 63'd9223372035854775807, '0, 1'b0, '0,
            cmi_pkg::SRC_FALLBACK, 1'b0);
        row(cmi_pkg::REQ_QUERY, 32'd2000, '0, '0, 1'b1, 63'd9223372035854775807,
            cmi_pkg::SRC_SINGLE, 1'b0);
        row(cmi_pkg::REQ_QUERY, 32'd3000, '0, '0, 1'b1, cmi_pkg::HOST_MAX,
            cmi_pkg::SRC_SINGLE, 1'b0);
        row(cmi_pkg::REQ_QUERY, 32'd3001, '0, '0, 1'b1, cmi_pkg::HOST_MAX,
            cmi_pkg::SRC_SINGLE, 1'b1);
        row(cmi_pkg::REQ_QUERY, 32'hFFFF_FFFF, '0, '0, 1'b1, cmi_pkg::HOST_MAX,
            cmi_pkg::SRC_SINGLE, 1'b1);
        row(cmi_pkg::REQ_QUERY, 32'd0, '0, '0, 1'b1, 63'd9223372033854775807,
            cmi_pkg::SRC_SINGLE, 1'b0);
        row(cmi_pkg::REQ_QUERY, 32'd1999, '0, '0, 1'b0, '0, cmi_pkg::SRC_FALLBACK, 1'b0);
        // Two pairs with falling host time.
        row(cmi_pkg::REQ_RECORD, 32'd5000, 63'd10000000000, '0, 1'b0, '0,
            cmi_pkg::SRC_FALLBACK, 1'b0);
        row(cmi_pkg::REQ_QUERY, 32'd3500, '0, '0, 1'b0, '0, cmi_pkg::SRC_FALLBACK, 1'b0);
        row(cmi_pkg::REQ_QUERY, 32'd2000, '0, '0, 1'b1, 63'd9223372035854775807,
            cmi_pkg::SRC_INTERP, 1'b0);
        row(cmi_pkg::REQ_QUERY, 32'd5000, '0, '0, 1'b1, 63'd10000000000,
            cmi_pkg::SRC_INTERP, 1'b0);
        row(cmi_pkg::REQ_QUERY, 32'd6000, '0, '0, 1'b1, 63'd10000000000,
            cmi_pkg::SRC_NEWEST, 1'b0);
        row(cmi_pkg::REQ_QUERY, 32'd1000, '0, '0, 1'b1, 63'd10000000000,
            cmi_pkg::SRC_NEWEST, 1'b0);
        // Equal keys reached only through the last pair.
        row(cmi_pkg::REQ_RECORD, 32'd100, 63'd7, '0, 1'b0, '0, cmi_pkg::SRC_FALLBACK, 1'b0);
        row(cmi_pkg::REQ_RECORD, 32'd100, 63'd9, '0, 1'b0, '0, cmi_pkg::SRC_FALLBACK, 1'b0);
        row(cmi_pkg::REQ_QUERY, 32'd100, '0, '0, 1'b1, 63'd9, cmi_pkg::SRC_EQUAL, 1'b0);
        row(cmi_pkg::REQ_QUERY, 32'hFFFF_FFFF, '0, '0, 1'b1, 63'd9,
            cmi_pkg::SRC_NEWEST, 1'b0);
        // Full-range keys and host times.
        row(cmi_pkg::REQ_RECORD, 32'hFFFF_FFFF, cmi_pkg::HOST_MAX, '0, 1'b0, '0,
            cmi_pkg::SRC_FALLBACK, 1'b0);
        row(cmi_pkg::REQ_RECORD, 32'd0, '0, cmi_pkg::HOST_MAX, 1'b0, '0,
            cmi_pkg::SRC_FALLBACK, 1'b0);
        row(cmi_pkg::REQ_QUERY, 32'h8000_0000, cmi_pkg::HOST_MAX, '0, 1'b0, '0,
            cmi_pkg::SRC_FALLBACK, 1'b0);
        row(cmi_pkg::REQ_QUERY, 32'd0, '0, '0, 1'b1, '0, cmi_pkg::SRC_NEWEST, 1'b0);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            offer(directed_rows[i].req, directed_rows[i].dms, directed_rows[i].hns,
                  directed_rows[i].fb, directed_rows[i].typed, directed_rows[i].want);

        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = (phase == 1) ? 51 : (phase == 3) ? 16 : 0;
            stall_pct     = (phase == 2) ? 51 : (phase == 3) ? 16 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
                random_item();
        end

        // Hold off the receiver while queries keep arriving, then drain.
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_go       = 1'b1;
        for (int n = 0; n < 40; n++)
            offer(cmi_pkg::REQ_QUERY, pick_query_key(), rand_host(), rand_host(), 1'b0, '0);
        @(negedge clk);
        in_valid <= 1'b0;
        drain_results();
        for (int n = 0; n < 20; n++)
            random_item();

        @(negedge clk);
        in_valid <= 1'b0;
        drain_results();
        repeat (200) @(posedge clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: sim.f
sv/cmi_pkg.sv
sv/cmi_pair_mem.sv
sv/cmi_div.sv
sv/clock_mapping_interpolator_top.sv
verif/clock_mapping_interpolator_top_tb.sv
